FILE: hw/rtl/fcspq_pkg.sv
// Package: shared types and constants of the four-class strict priority queue.
package fcspq_pkg;

    localparam int NUM_CLASSES     = 4;
    localparam int CLASS_W         = 2;
    localparam int TAG_W           = 16;
    localparam int AGE_W           = 7;
    localparam int ENTRY_W         = TAG_W + AGE_W;
    localparam int DEF_QUEUE_DEPTH = 16;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [CLASS_W-1:0] CLS_RED    = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_YELLOW = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_GREEN  = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_WHITE  = 2'd3;

    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    typedef struct packed {
        logic               op;
        logic [CLASS_W-1:0] priority_class;
        logic [TAG_W-1:0]   entry_tag;
        logic [AGE_W-1:0]   entry_age;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [CLASS_W-1:0] out_class;
        logic [TAG_W-1:0]   out_tag;
        logic [AGE_W-1:0]   out_age;
        logic               all_empty;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

FILE: hw/rtl/fcspq_ctrl.sv
// Controller: sequences one transaction through capture, queue update and response.
module fcspq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output fcspq_pkg::t_dp_cmd o_cmd
);
    import fcspq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_RESP: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_resp_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result is pending");

    a_accept_starts_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_cmd.exec)
        else $error("accepted transaction not executed next cycle");

    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> (o_out_valid && !o_cmd.exec))
        else $error("update cycle not followed by a result");
`endif

endmodule

FILE: hw/rtl/fcspq_dp.sv
// Datapath: entry memory, ring pointers, occupancy counters and result registers.
module fcspq_dp #(
    parameter int QUEUE_DEPTH = fcspq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fcspq_pkg::t_dp_cmd   i_cmd,
    input  fcspq_pkg::t_in_item  i_in,
    output fcspq_pkg::t_out_item o_out
);
    import fcspq_pkg::*;

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int OCC_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W    = CLASS_W + PTR_W;
    localparam int MEM_DEPTH = NUM_CLASSES << PTR_W;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

    logic [ENTRY_W-1:0] r_mem [MEM_DEPTH];

    t_in_item           r_item;
    logic [PTR_W-1:0]   r_rp  [NUM_CLASSES];
    logic [PTR_W-1:0]   r_wp  [NUM_CLASSES];
    logic [OCC_W-1:0]   r_occ [NUM_CLASSES];
    logic [PTR_W-1:0]   n_rp  [NUM_CLASSES];
    logic [PTR_W-1:0]   n_wp  [NUM_CLASSES];
    logic [OCC_W-1:0]   n_occ [NUM_CLASSES];

    t_status            r_status;
    t_status            n_status;
    logic [CLASS_W-1:0] r_out_class;
    logic               r_all_empty;
    logic [ENTRY_W-1:0] r_rd_data;

    logic [CLASS_W-1:0] pick;
    logic               found;
    logic               enq_full;
    logic               do_write;
    logic               do_read;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic               n_all_empty;

    // red wins: scan from white up so the lowest nonempty code is kept
    always_comb begin
        pick  = CLS_RED;
        found = 1'b0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (r_occ[c] != '0) begin
                pick  = CLASS_W'(c);
                found = 1'b1;
            end
        end
    end

    assign enq_full = (r_occ[r_item.priority_class] == OCC_FULL);
    assign do_write = i_cmd.exec && (r_item.op == OP_ENQ) && !enq_full;
    assign do_read  = i_cmd.exec && (r_item.op == OP_DEQ) && found;
    assign wr_addr  = {r_item.priority_class, r_wp[r_item.priority_class]};
    assign rd_addr  = {pick, r_rp[pick]};

    always_comb begin
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_occ    = r_occ;
        n_status = ST_ENQ;
        if (r_item.op == OP_ENQ) begin
            if (enq_full) begin
                n_status = ST_FULL;
            end else begin
                n_status = ST_ENQ;
                n_wp[r_item.priority_class] = (r_wp[r_item.priority_class] == PTR_LAST) ?
                    '0 : r_wp[r_item.priority_class] + 1'b1;
                n_occ[r_item.priority_class] = r_occ[r_item.priority_class] + 1'b1;
            end
        end else begin
            if (found) begin
                n_status    = ST_DEQ;
                n_rp[pick]  = (r_rp[pick] == PTR_LAST) ? '0 : r_rp[pick] + 1'b1;
                n_occ[pick] = r_occ[pick] - 1'b1;
            end else begin
                n_status = ST_EMPTY;
            end
        end
        n_all_empty = 1'b1;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (n_occ[c] != '0) n_all_empty = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_rp[c]  <= '0;
                r_wp[c]  <= '0;
                r_occ[c] <= '0;
            end
        end else if (i_cmd.exec) begin
            r_rp  <= n_rp;
            r_wp  <= n_wp;
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in;
        end
        if (i_cmd.exec) begin
            r_status    <= n_status;
            r_out_class <= found ? pick : CLS_RED;
            r_all_empty <= n_all_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[wr_addr] <= {r_item.entry_tag, r_item.entry_age};
        end
        if (do_read) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_comb begin
        o_out           = '0;
        o_out.status    = r_status;
        o_out.all_empty = r_all_empty;
        if (r_status == ST_DEQ) begin
            o_out.out_class = r_out_class;
            o_out.out_tag   = r_rd_data[ENTRY_W-1:AGE_W];
            o_out.out_age   = r_rd_data[AGE_W-1:0];
        end
    end

`ifndef SYNTHESIS
    a_occ_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ[0] <= OCC_FULL) && (r_occ[1] <= OCC_FULL) &&
        (r_occ[2] <= OCC_FULL) && (r_occ[3] <= OCC_FULL))
        else $error("queue occupancy above depth");

    a_enq_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_write |=> (r_occ[r_item.priority_class] ==
                      $past(r_occ[r_item.priority_class]) + 1'b1))
        else $error("enqueue did not bump occupancy");

    a_deq_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_read |=> ((r_status == ST_DEQ) && (r_out_class == $past(pick))))
        else $error("dequeue result class mismatch");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && !found && (r_item.op == OP_DEQ)) |=>
        ((r_status == ST_EMPTY) && r_all_empty))
        else $error("empty dequeue misreported");
`endif

endmodule

FILE: hw/rtl/four_class_strict_priority_queue_unit.sv
// Four-class strict priority queue: one transaction at a time through capture, a
// queue update with one memory access and a result, held while the output stalls;
// the next transaction is taken the cycle after the result is taken. Each
// class (red, yellow, green, white, highest first) is a ring of QUEUE_DEPTH entries
// in one shared entry memory with a registered read; no clearing pass after reset.
module four_class_strict_priority_queue_unit #(
    parameter int QUEUE_DEPTH = fcspq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  fcspq_pkg::t_in_item  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output fcspq_pkg::t_out_item o_out
);
    import fcspq_pkg::*;

    t_dp_cmd cmd;

    fcspq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    fcspq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
